[src/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for differential drive odometry
// Status codes, register indices, sequencer states, fixed-point constants,
// the CORDIC arctangent table in binary-angle units and 32-bit saturation.
// ----------------------------------------------------------------------------
package ddo_pkg;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_LATCHED  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_RESEEDED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_LEFT_RADIUS  = 2'd0,
    REG_RIGHT_RADIUS = 2'd1,
    REG_SEPARATION   = 2'd2,
    REG_COUNTS       = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMUL,
    S_CRND,
    S_DMUL,
    S_DLOAD,
    S_DIV,
    S_DEND,
    S_CINIT,
    S_CORD,
    S_XMUL,
    S_XADD,
    S_YMUL,
    S_YADD,
    S_HMUL,
    S_DONE
  } state_t;

  localparam int DIV_W = 64;

  localparam logic [33:0] TWO_PI_Q29      = 34'd3373259426;
  localparam logic [33:0] RAD_TO_BA       = 34'd683565276;
  localparam logic [33:0] CORDIC_INV_GAIN = 34'd652032874;

  localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

  localparam logic [31:0] ATAN_BA [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] r;
    if (v > S32_MAX_W) r = S32_MAX_W;
    else if (v < S32_MIN_W) r = S32_MIN_W;
    else r = v;
    return r[31:0];
  endfunction

endpackage

[src/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry: wheel odometry with Euler pose integration
// Turns absolute encoder counts into an updated x, y and heading.
// ----------------------------------------------------------------------------
// A reseed, an invalid-configuration sample or the first sample after reseed
// goes from idle straight to the done state. A full pose update runs three
// 64-step restoring divisions (one per wheel distance and one for the heading
// change) and the CORDIC steps, and one shared 34x34 multiplier serves every
// product. The input is stalled while an item is at work; a finished result
// waits in the output register and the next item may be taken meanwhile.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24,
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic signed [31:0] seed_x,
  input  logic signed [31:0] seed_y,
  input  logic [31:0] seed_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0] heading
);

  localparam int CNT_W = $clog2(ddo_pkg::DIV_W);

  logic [23:0] left_radius, right_radius, wheel_separation;
  logic [15:0] counts_per_rev;

  ddo_pkg::state_t state, state_next;

  logic signed [31:0] x_position, y_position;
  logic [31:0] heading_angle;
  logic [COUNTER_BITS-1:0] last_left, last_right;
  logic primed;

  ddo_pkg::status_t res_status;
  logic signed [31:0] delta_l, delta_r, dist_l, dist_r;
  logic wheel;
  logic div_hd;
  logic signed [33:0] circ;
  logic signed [67:0] prod;
  logic signed [33:0] mul_a, mul_b;

  logic [23:0] div_d;
  logic [ddo_pkg::DIV_W-1:0] div_q;
  logic [24:0] div_rem;
  logic div_neg;
  logic [CNT_W-1:0] div_cnt;

  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [4:0] ci;
  logic [1:0] quad;
  logic signed [33:0] cosv, sinv;

  logic accept;
  logic cfg_ok;
  logic [COUNTER_BITS-1:0] cur_l, cur_r;
  logic signed [COUNTER_BITS-1:0] dl_s, dr_s;
  logic signed [32:0] wsum, wdiff;

  // Round a product to nearest over 2^31, ties away from zero.
  function automatic logic signed [65:0] rnd31(input logic signed [67:0] p);
    logic [67:0] m;
    logic [67:0] q;
    m = p[67] ? 68'(-p) : 68'(p);
    q = (m + (68'd1 << 30)) >> 31;
    return p[67] ? -$signed(q[65:0]) : $signed(q[65:0]);
  endfunction

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != ddo_pkg::S_IDLE);
  assign cfg_ok  = (left_radius != '0) && (right_radius != '0) &&
                   (wheel_separation != '0) && (counts_per_rev != '0);
  assign cur_l   = left_count[COUNTER_BITS-1:0];
  assign cur_r   = right_count[COUNTER_BITS-1:0];
  assign dl_s    = $signed(cur_l - last_left);
  assign dr_s    = $signed(cur_r - last_right);
  assign wsum    = 33'(dist_l) + 33'(dist_r);
  assign wdiff   = 33'(dist_r) - 33'(dist_l);

  always_comb begin
    case (quad)
      2'd0:    begin cosv = cx;  sinv = cy;  end
      2'd1:    begin cosv = -cy; sinv = cx;  end
      2'd2:    begin cosv = -cx; sinv = -cy; end
      default: begin cosv = cy;  sinv = -cx; end
    endcase
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ddo_pkg::S_CMUL: begin
        mul_a = $signed({10'd0, wheel ? right_radius : left_radius});
        mul_b = $signed(ddo_pkg::TWO_PI_Q29);
      end
      ddo_pkg::S_DMUL: begin
        mul_a = 34'(wheel ? delta_r : delta_l);
        mul_b = circ;
      end
      ddo_pkg::S_XMUL: begin
        mul_a = 34'(wsum);
        mul_b = cosv;
      end
      ddo_pkg::S_YMUL: begin
        mul_a = 34'(wsum);
        mul_b = sinv;
      end
      ddo_pkg::S_HMUL: begin
        mul_a = 34'(wdiff);
        mul_b = $signed(ddo_pkg::RAD_TO_BA);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ddo_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        if (accept) begin
          if (!op && cfg_ok && primed) state_next = ddo_pkg::S_CMUL;
          else                         state_next = ddo_pkg::S_DONE;
        end
      end
      ddo_pkg::S_CMUL:  state_next = ddo_pkg::S_CRND;
      ddo_pkg::S_CRND:  state_next = ddo_pkg::S_DMUL;
      ddo_pkg::S_DMUL:  state_next = ddo_pkg::S_DLOAD;
      ddo_pkg::S_DLOAD: state_next = ddo_pkg::S_DIV;
      ddo_pkg::S_DIV: begin
        if (div_cnt == CNT_W'(ddo_pkg::DIV_W - 1)) state_next = ddo_pkg::S_DEND;
      end
      ddo_pkg::S_DEND: begin
        if (div_hd)      state_next = ddo_pkg::S_DONE;
        else if (!wheel) state_next = ddo_pkg::S_CMUL;
        else             state_next = ddo_pkg::S_CINIT;
      end
      ddo_pkg::S_CINIT: state_next = ddo_pkg::S_CORD;
      ddo_pkg::S_CORD: begin
        if (ci == 5'(CORDIC_STEPS - 1)) state_next = ddo_pkg::S_XMUL;
      end
      ddo_pkg::S_XMUL:  state_next = ddo_pkg::S_XADD;
      ddo_pkg::S_XADD:  state_next = ddo_pkg::S_YMUL;
      ddo_pkg::S_YMUL:  state_next = ddo_pkg::S_YADD;
      ddo_pkg::S_YADD:  state_next = ddo_pkg::S_HMUL;
      ddo_pkg::S_HMUL:  state_next = ddo_pkg::S_DLOAD;
      ddo_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = ddo_pkg::S_IDLE;
      end
      default: state_next = ddo_pkg::S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_radius      <= 24'd4096;
      right_radius     <= 24'd4096;
      wheel_separation <= 24'd21760;
      counts_per_rev   <= 16'd1440;
    end else if (cfg_we) begin
      unique case (ddo_pkg::reg_index_t'(cfg_index))
        ddo_pkg::REG_LEFT_RADIUS:  left_radius      <= cfg_data;
        ddo_pkg::REG_RIGHT_RADIUS: right_radius     <= cfg_data;
        ddo_pkg::REG_SEPARATION:   wheel_separation <= cfg_data;
        ddo_pkg::REG_COUNTS:       counts_per_rev   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Control and pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      last_left     <= '0;
      last_right    <= '0;
      primed        <= 1'b0;
      out_valid     <= 1'b0;
      wheel         <= 1'b0;
      div_hd        <= 1'b0;
    end else begin
      if (state == ddo_pkg::S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ddo_pkg::S_IDLE: begin
          wheel  <= 1'b0;
          div_hd <= 1'b0;
          if (accept) begin
            if (op) begin
              x_position    <= seed_x;
              y_position    <= seed_y;
              heading_angle <= seed_heading;
              last_left     <= '0;
              last_right    <= '0;
              primed        <= 1'b0;
            end else if (cfg_ok) begin
              last_left  <= cur_l;
              last_right <= cur_r;
              primed     <= 1'b1;
            end
          end
        end
        ddo_pkg::S_DEND: begin
          if (div_hd) begin
            heading_angle <= heading_angle + (div_neg ? -div_q[31:0] : div_q[31:0]);
          end else begin
            wheel <= 1'b1;
          end
        end
        ddo_pkg::S_XADD: begin
          x_position <= ddo_pkg::sat32(66'(x_position) + rnd31(prod));
        end
        ddo_pkg::S_YADD: begin
          y_position <= ddo_pkg::sat32(66'(y_position) + rnd31(prod));
        end
        ddo_pkg::S_HMUL: div_hd <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath: multiplier, divider and CORDIC registers.
  always_ff @(posedge clk) begin
    logic signed [67:0] circ_sum;
    logic [67:0] mag;
    logic [24:0] trial;
    logic signed [65:0] qs;
    circ_sum = prod + (68'sd1 <<< 28);
    mag      = prod[67] ? 68'(-prod) : 68'(prod);
    trial    = {div_rem[23:0], div_q[ddo_pkg::DIV_W-1]};
    qs       = div_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

    prod <= mul_a * mul_b;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        delta_l <= 32'(dl_s);
        delta_r <= 32'(dr_s);
        if (op)          res_status <= ddo_pkg::ST_RESEEDED;
        else if (!cfg_ok) res_status <= ddo_pkg::ST_INVALID;
        else if (!primed) res_status <= ddo_pkg::ST_LATCHED;
        else             res_status <= ddo_pkg::ST_UPDATED;
        div_d <= {8'd0, counts_per_rev};
      end
      ddo_pkg::S_CRND: circ <= 34'(circ_sum >>> 29);
      ddo_pkg::S_DLOAD: begin
        div_neg <= prod[67];
        div_q   <= mag[ddo_pkg::DIV_W-1:0] + ddo_pkg::DIV_W'(div_d >> 1);
        div_rem <= '0;
        div_cnt <= '0;
      end
      ddo_pkg::S_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (trial >= {1'b0, div_d}) begin
          div_rem <= trial - {1'b0, div_d};
          div_q   <= {div_q[ddo_pkg::DIV_W-2:0], 1'b1};
        end else begin
          div_rem <= trial;
          div_q   <= {div_q[ddo_pkg::DIV_W-2:0], 1'b0};
        end
      end
      ddo_pkg::S_DEND: begin
        if (!div_hd) begin
          if (wheel) dist_r <= ddo_pkg::sat32(qs);
          else       dist_l <= ddo_pkg::sat32(qs);
        end
      end
      ddo_pkg::S_CINIT: begin
        quad <= heading_angle[31:30] + {1'b0, heading_angle[29]};
        cz   <= $signed({3'b000, heading_angle[29:0] + 30'h20000000}) - 33'sh20000000;
        cx   <= $signed(ddo_pkg::CORDIC_INV_GAIN);
        cy   <= '0;
        ci   <= '0;
      end
      ddo_pkg::S_CORD: begin
        ci <= ci + 1'b1;
        if (!cz[32]) begin
          cx <= cx - (cy >>> ci);
          cy <= cy + (cx >>> ci);
          cz <= cz - $signed({1'b0, ddo_pkg::ATAN_BA[ci]});
        end else begin
          cx <= cx + (cy >>> ci);
          cy <= cy - (cx >>> ci);
          cz <= cz + $signed({1'b0, ddo_pkg::ATAN_BA[ci]});
        end
      end
      ddo_pkg::S_HMUL: div_d <= wheel_separation;
      ddo_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          status  <= res_status;
          pos_x   <= x_position;
          pos_y   <= y_position;
          heading <= heading_angle;
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/sv/tb_differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry: self-checking bench for wheel odometry
// Drives encoder samples and reseeds through the valid/stall input, predicts
// the pose for each transfer with its own fixed-point model, and compares
// every output transfer field by field. Configuration changes between phases.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 24;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic        op;
    logic [31:0] lc, rc, sx, sy, sh;
  } odo_item_t;

  typedef struct {
    ddo_pkg::status_t st;
    logic [31:0] x, y, h;
  } pose_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic op = 0;
  logic signed [31:0] left_count = 0, right_count = 0, seed_x = 0, seed_y = 0;
  logic [31:0] seed_heading = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] status;
  logic signed [31:0] pos_x, pos_y;
  logic [31:0] heading;

  differential_drive_odometry u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  odo_item_t pending[$];
  pose_t     expected_poses[$];
  longint cycles = 0, mismatches = 0, accepted = 0, checked = 0, updates = 0;
  int idle_pct = 30;
  bit hold_rx = 0;

  // Predictor state and configuration.
  longint m_lr, m_rr, m_sep, m_cpr, m_x, m_y;
  logic [31:0] m_head, m_ll, m_lrt;
  bit m_primed;

  function automatic longint clamp32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >= 0 ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint wheel_mm(logic [31:0] cur, logic [31:0] prev, longint rad);
    logic [31:0] d;
    longint circ;
    d = cur - prev;
    circ = round_div(rad * 64'd3373259426, 64'd1 << 29);
    return clamp32(round_div(longint'($signed(d)) * circ, m_cpr));
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] r;
    longint x, y, z, nx;
    r = ang + 32'h20000000;
    z = longint'(r & 32'h3FFFFFFF) - 64'h20000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= ddo_pkg::ATAN_BA[i];
      end else begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += ddo_pkg::ATAN_BA[i];
      end
      x = nx;
    end
    case (r[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_pose(input odo_item_t it);
    pose_t p;
    longint l, r, c, s, dth;
    if (it.op) begin
      m_x = longint'($signed(it.sx)); m_y = longint'($signed(it.sy));
      m_head = it.sh; m_ll = 0; m_lrt = 0; m_primed = 0;
      p.st = ddo_pkg::ST_RESEEDED;
    end else if (m_lr == 0 || m_rr == 0 || m_sep == 0 || m_cpr == 0) begin
      p.st = ddo_pkg::ST_INVALID;
    end else if (!m_primed) begin
      m_ll = it.lc; m_lrt = it.rc; m_primed = 1;
      p.st = ddo_pkg::ST_LATCHED;
    end else begin
      l = wheel_mm(it.lc, m_ll, m_lr);
      r = wheel_mm(it.rc, m_lrt, m_rr);
      m_ll = it.lc; m_lrt = it.rc;
      rotate(m_head, c, s);
      // Products stay inside 64 bits: |l+r| < 2^33, |cos| <= 2^30.
      m_x = clamp32(m_x + round_div((l + r) * c, 64'd1 << 31));
      m_y = clamp32(m_y + round_div((l + r) * s, 64'd1 << 31));
      dth = round_div((r - l) * 64'd683565276, m_sep);
      m_head = m_head + dth[31:0];
      p.st = ddo_pkg::ST_UPDATED;
      updates++;
    end
    p.x = m_x[31:0]; p.y = m_y[31:0]; p.h = m_head;
    expected_poses.push_back(p);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_pose(pending.pop_front());
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1;
          op <= pending[0].op;
          left_count <= pending[0].lc; right_count <= pending[0].rc;
          seed_x <= pending[0].sx; seed_y <= pending[0].sy;
          seed_heading <= pending[0].sh;
        end else if (!(in_valid && !in_stall && pending.size() != 0 &&
                       idle_pct == 0)) begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    pose_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
        end else begin
          e = expected_poses.pop_front();
          checked++;
          if (status !== e.st || pos_x !== e.x || pos_y !== e.y || heading !== e.h) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp st=%0d x=%h y=%h h=%h got st=%0d x=%h y=%h h=%h",
                       checked, e.st, e.x, e.y, e.h, status, pos_x, pos_y, heading);
          end
        end
      end
      out_stall <= hold_rx ? 1'b1 : ($urandom_range(99) < idle_pct);
    end
  end

  task automatic write_reg(input ddo_pkg::reg_index_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      ddo_pkg::REG_LEFT_RADIUS:  m_lr = val;
      ddo_pkg::REG_RIGHT_RADIUS: m_rr = val;
      ddo_pkg::REG_SEPARATION:   m_sep = val;
      default:                   m_cpr = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending.size() != 0 || expected_poses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic odo_item_t mk(logic o, logic [31:0] l, logic [31:0] r,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] h);
    odo_item_t it;
    it.op = o; it.lc = l; it.rc = r; it.sx = x; it.sy = y; it.sh = h;
    return it;
  endfunction

  function automatic logic [31:0] step_count(logic [31:0] prev);
    case ($urandom_range(9))
      0: return $urandom;
      1: return prev + 32'h80000000 + $urandom_range(1);
      default: return prev + $urandom_range(4000) - 2000;
    endcase
  endfunction

  task automatic random_run(input int n);
    logic [31:0] l, r;
    l = $urandom; r = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0)
        pending.push_back(mk(1, $urandom, $urandom, $urandom >> $urandom_range(31),
                             $urandom >> $urandom_range(31), $urandom));
      else begin
        l = step_count(l); r = step_count(r);
        pending.push_back(mk(0, l, r, $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    m_lr = 4096; m_rr = 4096; m_sep = 21760; m_cpr = 1440;
    m_x = 0; m_y = 0; m_head = 0; m_ll = 0; m_lrt = 0; m_primed = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: first sample latches, extremes, wraps, saturation, reseed.
    pending.push_back(mk(0, 32'd100, 32'd50, 0, 0, 0));
    pending.push_back(mk(0, 32'd1540, 32'd1490, 0, 0, 0));
    pending.push_back(mk(0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
    pending.push_back(mk(0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
    pending.push_back(mk(0, 32'hFFFFFFFF, 32'h00000000, 0, 0, 0));
    pending.push_back(mk(0, 32'h00000005, 32'hFFFFFFF0, 0, 0, 0));
    pending.push_back(mk(1, 0, 0, 32'h7FFFFF00, 32'h80000100, 32'h40000000));
    pending.push_back(mk(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
    pending.push_back(mk(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
    pending.push_back(mk(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                         32'hFFFFFFFF));
    pending.push_back(mk(0, 0, 0, 0, 0, 0));
    pending.push_back(mk(0, 32'h40000000, 32'h40000000, 0, 0, 0));
    pending.push_back(mk(1, 0, 0, 0, 0, 32'h20000000));
    pending.push_back(mk(0, 0, 0, 0, 0, 0));
    pending.push_back(mk(0, 32'd720, 32'd720, 0, 0, 0));
    pending.push_back(mk(1, 0, 0, 0, 0, 32'hA0000000));
    pending.push_back(mk(0, 0, 0, 0, 0, 0));
    pending.push_back(mk(0, 32'd1000, 32'd3000, 0, 0, 0));
    drain();

    // Large wheels, one count per revolution: distances saturate.
    write_reg(ddo_pkg::REG_LEFT_RADIUS, 24'hFFFFFF);
    write_reg(ddo_pkg::REG_RIGHT_RADIUS, 24'hFFFFFF);
    write_reg(ddo_pkg::REG_SEPARATION, 24'd1);
    write_reg(ddo_pkg::REG_COUNTS, 24'd1);
    pending.push_back(mk(0, 32'd10, 32'd20, 0, 0, 0));
    pending.push_back(mk(0, 32'd9000, 32'hFFFF0000, 0, 0, 0));
    random_run(60);
    drain();

    // Each register zero in turn gives an invalid configuration.
    write_reg(ddo_pkg::REG_COUNTS, 24'd0);
    random_run(8);
    drain();
    write_reg(ddo_pkg::REG_COUNTS, 24'hFFFF);
    write_reg(ddo_pkg::REG_SEPARATION, 24'd0);
    random_run(8);
    drain();
    write_reg(ddo_pkg::REG_SEPARATION, 24'hFFFFFF);
    write_reg(ddo_pkg::REG_LEFT_RADIUS, 24'd0);
    random_run(8);
    drain();
    write_reg(ddo_pkg::REG_LEFT_RADIUS, 24'd1);
    write_reg(ddo_pkg::REG_RIGHT_RADIUS, 24'd0);
    random_run(8);
    drain();

    // Smallest nonzero wheel radii, with the largest separation and counts per revolution.
    write_reg(ddo_pkg::REG_RIGHT_RADIUS, 24'd1);
    random_run(60);
    drain();

    // Typical robot setting, with a long receiver hold-off.
    write_reg(ddo_pkg::REG_LEFT_RADIUS, 24'd8000);
    write_reg(ddo_pkg::REG_RIGHT_RADIUS, 24'd8100);
    write_reg(ddo_pkg::REG_SEPARATION, 24'd40000);
    write_reg(ddo_pkg::REG_COUNTS, 24'd2048);
    random_run(200);
    hold_rx = 1;
    repeat (2000) @(posedge clk);
    hold_rx = 0;
    drain();

    // A stretch with no idling at all.
    idle_pct = 0;
    random_run(150);
    drain();
    idle_pct = 30;

    write_reg(ddo_pkg::REG_LEFT_RADIUS, 24'($urandom));
    write_reg(ddo_pkg::REG_RIGHT_RADIUS, 24'($urandom));
    write_reg(ddo_pkg::REG_SEPARATION, 24'($urandom));
    write_reg(ddo_pkg::REG_COUNTS, 24'($urandom_range(65535, 1)));
    random_run(200);
    drain();

    $display("covered %0d transfers, %0d full pose updates, several register settings",
             accepted, updates);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
src/ddo_pkg.sv
src/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
